[rtl/swbrl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swbrl_pkg
// Shared types, widths and codes for the sliding-window byte-rate limiter.
// ----------------------------------------------------------------------------
package swbrl_pkg;

  // window log geometry
  localparam int LOG_DEPTH = 64;
  localparam int PTR_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int FILL_W    = $clog2(LOG_DEPTH + 1);

  // field widths
  localparam int BYTE_W    = 24;
  localparam int STAMP_W   = 32;
  localparam int COUNT_W   = 32;
  localparam int BUDGET_W  = 32;
  localparam int WIN_W     = 16;
  localparam int WB_W      = 31;
  localparam int HELD_W    = 7;
  localparam int ENTRY_W   = BYTE_W + STAMP_W;

  // running sums: the window sum holds LOG_DEPTH full entries without overflow,
  // the all-time total holds a saturated count of full entries
  localparam int WSUM_W    = BYTE_W + PTR_W + 1;
  localparam int TOTAL_W   = BYTE_W + COUNT_W;
  localparam int PERM_W    = (WSUM_W + 1 > BUDGET_W + 1) ? WSUM_W + 1 : BUDGET_W + 1;

  // saturation limits of the result fields
  localparam logic [WB_W-1:0]   WB_MAX   = {WB_W{1'b1}};
  localparam logic [HELD_W-1:0] HELD_MAX = {HELD_W{1'b1}};

  // divider: quotient never exceeds one byte count
  localparam int QUOT_W    = BYTE_W;
  localparam int DCNT_W    = $clog2(QUOT_W + 1);

  // input queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS     = 2'd1;
  localparam logic [BUDGET_W-1:0]  BUDGET_RESET         = 32'd1000000;
  localparam logic [WIN_W-1:0]     WINDOW_RESET         = 16'd1000;

  // item kinds
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_TXN  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] byte_count;
  } item_t;

  typedef struct packed {
    logic [BUDGET_W-1:0] bytes_per_window;
    logic [WIN_W-1:0]    window_ticks;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EVICT,
    ST_WRITE,
    ST_EXP_RD,
    ST_EXP_CHK,
    ST_DIV,
    ST_DIV_WAIT,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

[rtl/swbrl_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swbrl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swbrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/swbrl_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swbrl_front
// Accepts input words and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module swbrl_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output logic                             item_stall,
  input  wire logic                        mode,
  input  wire logic [swbrl_pkg::BYTE_W-1:0] byte_count,
  output logic                             q_valid,
  output swbrl_pkg::item_t                 q_item,
  input  wire logic                        q_pop
);

  import swbrl_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign item_stall = (count == QCNT_W'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign q_valid    = (count != '0);
  assign pop        = q_pop && q_valid;
  assign q_item     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{mode: mode, byte_count: byte_count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/swbrl_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swbrl_div
// Restoring divider, one quotient bit per cycle. The dividend must be below
// divisor * 2^QUOT_W so that the quotient fits in QUOT_W bits.
// ----------------------------------------------------------------------------
module swbrl_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [swbrl_pkg::TOTAL_W-1:0] dividend,
  input  wire logic [swbrl_pkg::COUNT_W-1:0] divisor,
  output logic                               done,
  output logic      [swbrl_pkg::QUOT_W-1:0]  quotient
);

  import swbrl_pkg::*;

  logic                busy;
  logic [DCNT_W-1:0]   cnt;
  logic [COUNT_W-1:0]  rem;
  logic [QUOT_W-1:0]   low;
  logic [COUNT_W:0]    shifted;
  logic [COUNT_W:0]    trial;
  logic                qbit;
  logic [COUNT_W-1:0]  rem_next;

  always_comb begin
    shifted  = {rem, low[QUOT_W-1]};
    trial    = shifted - {1'b0, divisor};
    qbit     = !trial[COUNT_W];
    rem_next = qbit ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(QUOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[TOTAL_W-1 -: COUNT_W];
      low <= dividend[QUOT_W-1:0];
    end else if (busy) begin
      rem      <= rem_next;
      low      <= {low[QUOT_W-2:0], 1'b0};
      quotient <= {quotient[QUOT_W-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

[rtl/swbrl_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// swbrl_back
// Sequencer that logs transactions, retires expired entries one per pass,
// runs the mean division and registers one result per word.
// ----------------------------------------------------------------------------
module swbrl_back (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire swbrl_pkg::cfg_t              cfg,
  input  wire logic                         q_valid,
  input  wire swbrl_pkg::item_t             q_item,
  output logic                              q_pop,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic                              permit,
  output logic      [swbrl_pkg::WB_W-1:0]   window_bytes,
  output logic      [swbrl_pkg::BYTE_W-1:0] mean_bytes,
  output logic      [swbrl_pkg::HELD_W-1:0] entries_held
);

  import swbrl_pkg::*;

  state_t              state;
  state_t              state_next;

  logic                cur_mode;
  logic [BYTE_W-1:0]   cur_bytes;
  logic [PTR_W-1:0]    head_ptr;
  logic [PTR_W-1:0]    tail_ptr;
  logic [FILL_W-1:0]   fill_count;
  logic [STAMP_W-1:0]  now_ticks;
  logic [WSUM_W-1:0]   window_sum;
  logic [TOTAL_W-1:0]  total_bytes;
  logic [COUNT_W-1:0]  txn_count;
  logic [BYTE_W-1:0]   mean;

  logic                ram_rd_en;
  logic                ram_wr_en;
  logic [ENTRY_W-1:0]  ram_rd_data;
  logic [BYTE_W-1:0]   rd_bytes;
  logic [STAMP_W-1:0]  rd_stamp;
  logic [STAMP_W-1:0]  age;
  logic                expired;
  logic                log_full;
  logic                log_empty;

  logic                div_start;
  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;

  logic                res_load;
  logic                load_ok;
  logic [PERM_W-1:0]   wsum_ext;
  logic [PERM_W-1:0]   need;
  logic [PERM_W-1:0]   budget_ext;
  logic [PTR_W-1:0]    head_inc;
  logic [PTR_W-1:0]    tail_inc;

  swbrl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LOG_DEPTH)
  ) u_log (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (tail_ptr),
    .wr_data ({cur_bytes, now_ticks}),
    .rd_en   (ram_rd_en),
    .rd_addr (head_ptr),
    .rd_data (ram_rd_data)
  );

  swbrl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (total_bytes),
    .divisor  (txn_count),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign rd_bytes   = ram_rd_data[ENTRY_W-1 -: BYTE_W];
  assign rd_stamp   = ram_rd_data[STAMP_W-1:0];
  assign age        = now_ticks - rd_stamp;
  assign expired    = age > STAMP_W'(cfg.window_ticks);
  assign log_full   = (fill_count == FILL_W'(LOG_DEPTH));
  assign log_empty  = (fill_count == '0);
  assign head_inc   = (head_ptr == PTR_W'(LOG_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
  assign tail_inc   = (tail_ptr == PTR_W'(LOG_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;
  assign load_ok    = !result_valid || !result_stall;

  assign wsum_ext   = PERM_W'(window_sum);
  assign need       = wsum_ext + PERM_W'(mean);
  assign budget_ext = PERM_W'(cfg.bytes_per_window);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (q_valid) state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (cur_mode == MODE_TXN) begin
          state_next = log_full ? ST_EVICT : ST_WRITE;
        end else begin
          state_next = ST_EXP_RD;
        end
      end
      ST_EVICT:    state_next = ST_WRITE;
      ST_WRITE:    state_next = ST_EXP_RD;
      ST_EXP_RD:   state_next = log_empty ? ST_DIV : ST_EXP_CHK;
      ST_EXP_CHK:  state_next = expired ? ST_EXP_RD : ST_DIV;
      ST_DIV:      state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_next = ST_RESULT;
      ST_RESULT:   if (load_ok) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    ram_rd_en = 1'b0;
    ram_wr_en = 1'b0;
    div_start = 1'b0;
    res_load  = 1'b0;
    case (state)
      ST_IDLE:    q_pop     = q_valid;
      ST_UPDATE:  ram_rd_en = (cur_mode == MODE_TXN) && log_full;
      ST_WRITE:   ram_wr_en = 1'b1;
      ST_EXP_RD:  ram_rd_en = !log_empty;
      ST_DIV:     div_start = 1'b1;
      ST_RESULT:  res_load  = load_ok;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      head_ptr    <= '0;
      tail_ptr    <= '0;
      fill_count  <= '0;
      now_ticks   <= '0;
      window_sum  <= '0;
      total_bytes <= '0;
      txn_count   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_UPDATE: begin
          if (cur_mode == MODE_TXN) begin
            // freeze the mean once the count saturates
            if (txn_count != '1) begin
              total_bytes <= total_bytes + TOTAL_W'(cur_bytes);
              txn_count   <= txn_count + 1'b1;
            end
          end else begin
            now_ticks <= now_ticks + 1'b1;
          end
        end
        ST_EVICT: begin
          window_sum <= window_sum - WSUM_W'(rd_bytes);
          head_ptr   <= head_inc;
          fill_count <= fill_count - 1'b1;
        end
        ST_WRITE: begin
          window_sum <= window_sum + WSUM_W'(cur_bytes);
          tail_ptr   <= tail_inc;
          fill_count <= fill_count + 1'b1;
        end
        ST_EXP_CHK: begin
          if (expired) begin
            window_sum <= window_sum - WSUM_W'(rd_bytes);
            head_ptr   <= head_inc;
            fill_count <= fill_count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // word and mean holding registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_mode  <= q_item.mode;
      cur_bytes <= q_item.byte_count;
    end
    if (state == ST_DIV_WAIT && div_done) begin
      mean <= (txn_count == '0) ? '0 : div_quot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      permit       <= budget_ext > need;
      window_bytes <= (wsum_ext > PERM_W'(WB_MAX)) ? WB_MAX : wsum_ext[WB_W-1:0];
      mean_bytes   <= mean;
      entries_held <= (32'(fill_count) > 32'(HELD_MAX)) ? HELD_MAX
                                                         : HELD_W'(fill_count);
    end
  end

endmodule
`default_nettype wire

[rtl/sliding_window_byte_rate_limiter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_byte_rate_limiter_top
// Sliding-window byte-rate limiter: logs transactions with their tick stamp,
// retires entries older than the window and reports sum, mean and permit.
// ----------------------------------------------------------------------------
// Each input word is a tick (mode 0) or a completed transaction (mode 1) and
// yields exactly one result word. Words enter a four-deep queue and are then
// handled one at a time by a sequencer. A transaction that finds the log full
// first evicts its oldest entry; every word then retires expired entries from
// the head one at a time, each through a registered read of the log RAM, and
// runs the 24-step restoring divider that forms the mean before its result is
// registered, where it may wait on a stall. No clearing pass follows reset.
// Write the configuration registers (index 0: byte budget per window, index 1:
// window length in ticks) only while no word is in flight.
module sliding_window_byte_rate_limiter_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [swbrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [swbrl_pkg::CFG_DAT_W-1:0] cfg_data,
  // input words
  input  wire logic                            item_valid,
  output logic                                 item_stall,
  input  wire logic                            mode,
  input  wire logic [swbrl_pkg::BYTE_W-1:0]    byte_count,
  // result words
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output logic                                 permit,
  output logic      [swbrl_pkg::WB_W-1:0]      window_bytes,
  output logic      [swbrl_pkg::BYTE_W-1:0]    mean_bytes,
  output logic      [swbrl_pkg::HELD_W-1:0]    entries_held
);

  import swbrl_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bytes_per_window <= BUDGET_RESET;
      cfg.window_ticks     <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BYTES_PER_WINDOW: cfg.bytes_per_window <= cfg_data[BUDGET_W-1:0];
        REG_WINDOW_TICKS:     cfg.window_ticks     <= cfg_data[WIN_W-1:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  swbrl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .mode       (mode),
    .byte_count (byte_count),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  swbrl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .permit       (permit),
    .window_bytes (window_bytes),
    .mean_bytes   (mean_bytes),
    .entries_held (entries_held)
  );

endmodule
`default_nettype wire

[test/sliding_window_byte_rate_limiter_top_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_byte_rate_limiter_top_test
// Self-checking bench for the sliding-window byte-rate limiter. A short
// table of directed words runs first, some with hand-worked results. Random
// phases follow, with bursts of transactions that overflow the log, runs of
// ticks that expire it, and mixed traffic. A result word with no hand-worked
// result is compared with a cycle-free predictor of the window log, the
// running mean and the permit test. Stalls are random on both sides.
// ----------------------------------------------------------------------------
module sliding_window_byte_rate_limiter_top_test;
  import swbrl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 400;
  // index beyond the register file: the write must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;

  typedef struct packed {
    logic              permit;
    logic [WB_W-1:0]   window_bytes;
    logic [BYTE_W-1:0] mean_bytes;
    logic [HELD_W-1:0] entries_held;
  } report_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic                 mode;
    logic [BYTE_W-1:0]    byte_count;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] reg_data;
    logic                 typed;
    report_t              want;
  } row_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_DAT_W-1:0] cfg_data     = '0;
  logic                 item_valid   = 1'b0;
  logic                 item_mode    = MODE_TICK;
  logic [BYTE_W-1:0]    item_bytes   = '0;
  logic                 result_stall = 1'b0;
  logic                 cfg_ready;
  logic                 item_stall;
  logic                 result_valid;
  logic                 permit;
  logic [WB_W-1:0]      window_bytes;
  logic [BYTE_W-1:0]    mean_bytes;
  logic [HELD_W-1:0]    entries_held;

  sliding_window_byte_rate_limiter_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .mode         (item_mode),
    .byte_count   (item_bytes),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .permit       (permit),
    .window_bytes (window_bytes),
    .mean_bytes   (mean_bytes),
    .entries_held (entries_held)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // predictor state: window log, tick clock, running sums, registers
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0]  log_bytes [LOG_DEPTH];
  logic [STAMP_W-1:0] log_stamp [LOG_DEPTH];
  int unsigned        log_head, log_tail, log_fill;
  logic [STAMP_W-1:0] tick_now;
  logic [63:0]        win_sum, all_bytes;
  logic [COUNT_W-1:0] all_txns;
  logic [BUDGET_W-1:0] budget;
  logic [WIN_W-1:0]   win_len;

  report_t report_queue [$];
  report_t arrived;
  row_t    script [$];

  int fail_count      = 0;
  int words_sent      = 0;
  int reports_checked = 0;
  int reg_writes      = 0;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int hold_asks       = 0;
  int hold_done       = 0;
  int hold_left       = 0;

  function automatic void retire_oldest();
    if (log_fill != 0) begin
      win_sum  -= log_bytes[log_head];
      log_head  = (log_head + 1) % LOG_DEPTH;
      log_fill--;
    end
  endfunction

  function automatic report_t predict_report(input logic m, input logic [BYTE_W-1:0] b);
    report_t            r;
    logic [63:0]        mean_q;
    logic [STAMP_W-1:0] age;
    bit                 aging;
    if (m == MODE_TICK) begin
      tick_now++;
    end else begin
      // full log: evict the oldest before logging
      if (log_fill >= LOG_DEPTH) retire_oldest();
      log_bytes[log_tail] = b;
      log_stamp[log_tail] = tick_now;
      log_tail = (log_tail + 1) % LOG_DEPTH;
      log_fill++;
      win_sum += b;
      if (all_txns != '1) begin
        all_bytes += b;
        all_txns++;
      end
    end
    aging = 1'b1;
    while (aging && log_fill != 0) begin
      age = tick_now - log_stamp[log_head];
      if (age > {16'd0, win_len}) retire_oldest();
      else aging = 1'b0;
    end
    mean_q = (all_txns == 0) ? 64'd0 : all_bytes / all_txns;
    if (mean_q > 64'hFF_FFFF) mean_q = 64'hFF_FFFF;
    r.permit       = ({32'd0, budget} > win_sum + mean_q);
    r.window_bytes = (win_sum > 64'h7FFF_FFFF) ? WB_MAX : win_sum[WB_W-1:0];
    r.mean_bytes   = mean_q[BYTE_W-1:0];
    r.entries_held = (log_fill > 127) ? HELD_MAX : HELD_W'(log_fill);
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_bytes();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return BYTE_W'($urandom_range(255));
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  task automatic send_word(input logic m, input logic [BYTE_W-1:0] b, input logic typed,
                           input report_t want);
    report_t prediction;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_mode  <= m;
    item_bytes <= b;
    do @(posedge clk); while (item_stall);
    prediction = predict_report(m, b);
    report_queue.insert(report_queue.size(), typed ? want : prediction);
    words_sent++;
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (report_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BYTES_PER_WINDOW: budget  = data;
      REG_WINDOW_TICKS:     win_len = data[WIN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic void word_row(input logic m, input logic [BYTE_W-1:0] b);
    row_t r;
    r            = '0;
    r.kind       = ROW_WORD;
    r.mode       = m;
    r.byte_count = b;
    script.insert(script.size(), r);
  endfunction

  function automatic void known_row(input logic m, input logic [BYTE_W-1:0] b,
                                    input report_t want);
    row_t r;
    r            = '0;
    r.kind       = ROW_WORD;
    r.mode       = m;
    r.byte_count = b;
    r.typed      = 1'b1;
    r.want       = want;
    script.insert(script.size(), r);
  endfunction

  function automatic void reg_row(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] data);
    row_t r;
    r           = '0;
    r.kind      = ROW_REG;
    r.reg_index = idx;
    r.reg_data  = data;
    script.insert(script.size(), r);
  endfunction

  // bursts of transactions (some past the log depth), tick runs, mixed words
  task automatic run_phase(input int count, input int send_pct, input int recv_pct,
                           input bit hold_mid, input logic [WIN_W-1:0] wlen,
                           input logic [BUDGET_W-1:0] budget_val);
    int   sent;
    int   pick;
    int   burst;
    bit   paused;
    bit   held;
    logic m;
    sent   = 0;
    paused = 1'b0;
    held   = 1'b0;
    write_register(REG_WINDOW_TICKS, {16'd0, wlen});
    write_register(REG_BYTES_PER_WINDOW, budget_val);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < count) begin
      if (!paused && sent >= count / 3) begin
        wait_drained();
        paused = 1'b1;
      end
      if (hold_mid && !held && sent >= count / 2) begin
        hold_asks++;
        held = 1'b1;
      end
      pick = $urandom_range(9);
      if (pick <= 3) burst = $urandom_range(1, (pick == 0) ? 80 : 12);
      else if (pick <= 6) burst = $urandom_range(1, (wlen + 2 > 40) ? 40 : wlen + 2);
      else burst = 8;
      repeat (burst) begin
        if (pick <= 3) m = MODE_TXN;
        else if (pick <= 6) m = MODE_TICK;
        else m = $urandom_range(1) ? MODE_TXN : MODE_TICK;
        send_word(m, pick_bytes(), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // receiver stall: random, with a long hold on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_asks != hold_done) begin
      result_stall <= 1'b1;
      hold_done    <= hold_asks;
      hold_left    <= LONG_HOLD;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (report_queue.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        arrived = report_queue[0];
        report_queue.delete(0);
        if (arrived.permit !== permit) begin
          $error("permit: expected %0d, got %0d", arrived.permit, permit);
          fail_count++;
        end
        if (arrived.window_bytes !== window_bytes) begin
          $error("window_bytes: expected %0d, got %0d", arrived.window_bytes, window_bytes);
          fail_count++;
        end
        if (arrived.mean_bytes !== mean_bytes) begin
          $error("mean_bytes: expected %0d, got %0d", arrived.mean_bytes, mean_bytes);
          fail_count++;
        end
        if (arrived.entries_held !== entries_held) begin
          $error("entries_held: expected %0d, got %0d", arrived.entries_held, entries_held);
          fail_count++;
        end
        reports_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, report_queue.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    log_head  = 0;
    log_tail  = 0;
    log_fill  = 0;
    tick_now  = '0;
    win_sum   = '0;
    all_bytes = '0;
    all_txns  = '0;
    budget    = BUDGET_RESET;
    win_len   = WINDOW_RESET;
    for (int i = 0; i < LOG_DEPTH; i++) begin
      log_bytes[i] = '0;
      log_stamp[i] = '0;
    end

    // directed table; hand-worked rows use the reset byte budget
    known_row(MODE_TICK, 24'h000000, '{1'b1, 31'd0, 24'd0, 7'd0});
    known_row(MODE_TXN,  24'h000000, '{1'b1, 31'd0, 24'd0, 7'd1});
    known_row(MODE_TXN,  24'hFFFFFF, '{1'b0, 31'd16777215, 24'd8388607, 7'd2});
    reg_row(REG_WINDOW_TICKS, 32'd0);
    // zero window: the next tick retires both, then expiry runs on an empty log
    known_row(MODE_TICK, 24'h123456, '{1'b0, 31'd0, 24'd8388607, 7'd0});
    known_row(MODE_TICK, 24'hFFFFFF, '{1'b0, 31'd0, 24'd8388607, 7'd0});
    word_row(MODE_TXN,  24'h000005);
    word_row(MODE_TICK, 24'h000000);
    reg_row(REG_BYTES_PER_WINDOW, 32'd0);
    word_row(MODE_TXN,  24'h000064);
    word_row(MODE_TXN,  24'hFFFFFF);
    reg_row(REG_BYTES_PER_WINDOW, 32'hFFFF_FFFF);
    reg_row(REG_WINDOW_TICKS, 32'h0000_FFFF);
    word_row(MODE_TXN,  24'hAAAAAA);
    word_row(MODE_TXN,  24'h555555);
    word_row(MODE_TICK, 24'hFFFFFF);
    word_row(MODE_TXN,  24'h000001);
    reg_row(REG_BYTES_PER_WINDOW, 32'd1);
    word_row(MODE_TXN,  24'h000000);
    word_row(MODE_TICK, 24'h000000);
    reg_row(REG_WINDOW_TICKS, 32'd1);
    word_row(MODE_TXN,  24'h800000);
    word_row(MODE_TICK, 24'h000000);
    word_row(MODE_TICK, 24'h000000);
    word_row(MODE_TXN,  24'h7FFFFF);
    reg_row(REG_UNUSED, 32'hDEAD_BEEF);
    word_row(MODE_TICK, 24'h000000);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 81;
    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) write_register(script[i].reg_index, script[i].reg_data);
      else send_word(script[i].mode, script[i].byte_count, script[i].typed, script[i].want);
    end

    run_phase(250, 25, 81, 1'b1, 16'($urandom_range(2, 12)),
              $urandom_range(1, 32'h1000_0000));
    run_phase(250, 81, 25, 1'b0, 16'($urandom_range(1, 6)), $urandom);
    run_phase(250, 0, 0, 1'b1, 16'($urandom_range(20, 70)),
              $urandom_range(32'h0100_0000, 32'h2000_0000));

    wait_drained();
    repeat (200) @(posedge clk);
    $display("%0d words sent, %0d results checked, %0d register writes",
             words_sent, reports_checked, reg_writes);
    $display("log overflow, tick expiry, zero window and budget, long result holds covered");
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
